/* design/kms_pkg.sv */
// ----------------------------------------------------------------------------
// kms_pkg: shared types and constants of the KMP stream matcher
// Item codes, sequencer states, the step unit control group and the
// fixed port widths.
// ----------------------------------------------------------------------------
package kms_pkg;

   localparam int MAX_PATTERN_DEFAULT = 1024;
   localparam int SYMBOL_BITS_DEFAULT = 32;

   localparam int FUNC_BITS        = 2;
   localparam int SYMBOL_PORT_BITS = 32;
   localparam int LEN_PORT_BITS    = 11;
   localparam int COUNT_BITS       = 32;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_TEXT   = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_SEED_LOAD,
      ST_FETCH,
      ST_COMPARE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_start;
      logic load_seed;
      logic step;
   } step_ctrl_type;

endpackage

/* design/kms_req_if.sv */
// ----------------------------------------------------------------------------
// kms_req_if: input item channel
// Valid/ready channel carrying one clear, append or text item.
// ----------------------------------------------------------------------------
interface kms_req_if import kms_pkg::*; ();

   logic                        valid;
   logic                        ready;
   logic [FUNC_BITS-1:0]        func;
   logic [SYMBOL_PORT_BITS-1:0] symbol;
   logic                        last;

   modport source (output valid, output func, output symbol, output last, input ready);
   modport sink   (input valid, input func, input symbol, input last, output ready);

endinterface

/* design/kms_rsp_if.sv */
// ----------------------------------------------------------------------------
// kms_rsp_if: result channel
// Valid/ready channel carrying one result per input item.
// ----------------------------------------------------------------------------
interface kms_rsp_if import kms_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic                     match;
   logic [COUNT_BITS-1:0]    match_count;
   logic [LEN_PORT_BITS-1:0] border_length;
   logic [LEN_PORT_BITS-1:0] pattern_length;
   logic                     overflow;

   modport source (output valid, output match, output match_count, output border_length,
                   output pattern_length, output overflow, input ready);
   modport sink   (input valid, input match, input match_count, input border_length,
                   input pattern_length, input overflow, output ready);

endinterface

/* design/kms_stores.sv */
// ----------------------------------------------------------------------------
// kms_stores: pattern symbol store and failure link store
// One write and one registered read port on each store.
// ----------------------------------------------------------------------------
module kms_stores import kms_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                pat_we,
   input  logic [$clog2(MAX_PATTERN)-1:0]      pat_wr_addr,
   input  logic [((SYMBOL_BITS < SYMBOL_PORT_BITS) ? SYMBOL_BITS : SYMBOL_PORT_BITS)-1:0]
                                               pat_wr_data,
   input  logic [$clog2(MAX_PATTERN)-1:0]      pat_rd_addr,
   output logic [((SYMBOL_BITS < SYMBOL_PORT_BITS) ? SYMBOL_BITS : SYMBOL_PORT_BITS)-1:0]
                                               pat_rd_data,
   input  logic                                link_we,
   input  logic [$clog2(MAX_PATTERN)-1:0]      link_wr_addr,
   input  logic [$clog2(MAX_PATTERN)-1:0]      link_wr_data,
   input  logic [$clog2(MAX_PATTERN)-1:0]      link_rd_addr,
   output logic [$clog2(MAX_PATTERN)-1:0]      link_rd_data
);

   localparam int SYM_W  = (SYMBOL_BITS < SYMBOL_PORT_BITS) ? SYMBOL_BITS : SYMBOL_PORT_BITS;
   localparam int ADDR_W = $clog2(MAX_PATTERN);

   logic [SYM_W-1:0]  pat_mem [MAX_PATTERN];
   logic [ADDR_W-1:0] link_mem [MAX_PATTERN];
   logic [SYM_W-1:0]  pat_rd_ff;
   logic [ADDR_W-1:0] link_rd_ff;

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_wr_addr] <= pat_wr_data;
      end
      pat_rd_ff <= pat_mem[pat_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      link_rd_ff <= link_mem[link_rd_addr];
   end

   assign pat_rd_data  = pat_rd_ff;
   assign link_rd_data = link_rd_ff;

endmodule

/* design/kms_step_unit.sv */
// ----------------------------------------------------------------------------
// kms_step_unit: shared compare-and-follow step of the failure link walk
// Holds the walk position, compares the symbol with the stored pattern
// symbol and either extends the prefix or drops back along a link.
// ----------------------------------------------------------------------------
module kms_step_unit import kms_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
   input  logic                                clock,
   input  step_ctrl_type                       ctrl,
   input  logic [$clog2(MAX_PATTERN)-1:0]      start_k,
   input  logic [((SYMBOL_BITS < SYMBOL_PORT_BITS) ? SYMBOL_BITS : SYMBOL_PORT_BITS)-1:0]
                                               symbol,
   input  logic [((SYMBOL_BITS < SYMBOL_PORT_BITS) ? SYMBOL_BITS : SYMBOL_PORT_BITS)-1:0]
                                               pat_rd_data,
   input  logic [$clog2(MAX_PATTERN)-1:0]      link_rd_data,
   output logic [$clog2(MAX_PATTERN)-1:0]      k,
   output logic                                done,
   output logic [$clog2(MAX_PATTERN+1)-1:0]    result
);

   localparam int ADDR_W = $clog2(MAX_PATTERN);
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

   logic [ADDR_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0]  res_ff, res_in;
   logic              hit;
   logic              at_zero;

   assign hit     = (symbol == pat_rd_data);
   assign at_zero = (k_ff == '0);
   assign done    = hit || at_zero;

   always_comb begin
      k_in   = k_ff;
      res_in = res_ff;
      if (ctrl.load_start) begin
         k_in = start_k;
      end else if (ctrl.load_seed) begin
         k_in = link_rd_data;
      end else if (ctrl.step) begin
         if (hit) begin
            res_in = LEN_W'(k_ff) + LEN_W'(1);
         end else if (at_zero) begin
            res_in = '0;
         end else begin
            // follow the failure link of the matched prefix, stored at index k - 1
            k_in = link_rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      res_ff <= res_in;
   end

   assign k      = k_ff;
   assign result = res_ff;

endmodule

/* design/kmp_stream_matcher.sv */
// ----------------------------------------------------------------------------
// kmp_stream_matcher: streaming Knuth-Morris-Pratt pattern matcher
// Builds a pattern one symbol at a time with incremental failure links and
// scans text symbols against it, counting overlapping occurrences.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per transfer: clear (empty the pattern), append
//   (add a pattern symbol) or text (scan one symbol; last ends the text).
//   rsp returns exactly one result per item: match flag, saturating count
//   of matches in the current text, pattern length, border of the whole
//   pattern and the overflow flag for appends dropped at capacity.
// Timing:
//   One item at a time; req.ready is high only while the sequencer idles.
//   Each compare is a store read (ST_FETCH), then a compare in the shared
//   step unit (ST_COMPARE). A text walk compares until the step unit is
//   done; an append seeds its walk with a link read (ST_SEED, ST_SEED_LOAD).
//   Clear, other codes, text on an empty pattern and appends to an empty or
//   full pattern go straight to the result load. The next transfer can come
//   once the load returns the sequencer to idle; the result shows on rsp
//   right after its load. Amortized, a text symbol takes about two compares.
// Reset and stall:
//   Reset empties the pattern and zeroes position, count and overflow;
//   the stores need no clearing pass, entries are read only once written.
//   A stalled rsp holds its result; the next item is still taken and
//   walked, and waits to load its result until the output register frees.
// ----------------------------------------------------------------------------
module kmp_stream_matcher import kms_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   kms_req_if.sink   req,
   kms_rsp_if.source rsp
);

   localparam int SYM_W  = (SYMBOL_BITS < SYMBOL_PORT_BITS) ? SYMBOL_BITS : SYMBOL_PORT_BITS;
   localparam int ADDR_W = $clog2(MAX_PATTERN);
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

   // sequencer
   state_type state_ff, state_in;

   // latched item
   logic [FUNC_BITS-1:0] func_ff, func_in;
   logic [SYM_W-1:0]     sym_ff, sym_in;
   logic                 last_ff, last_in;

   // matcher state
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [ADDR_W-1:0]     matched_ff, matched_in;
   logic [ADDR_W-1:0]     border_ff, border_in;
   logic [COUNT_BITS-1:0] occ_ff, occ_in;
   logic                  dropped_ff, dropped_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_match_ff, rsp_match_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic [LEN_PORT_BITS-1:0] rsp_border_ff, rsp_border_in;
   logic [LEN_PORT_BITS-1:0] rsp_length_ff, rsp_length_in;
   logic                     rsp_overflow_ff, rsp_overflow_in;

   // glue
   logic                  req_xfer;
   logic                  commit;
   logic                  full;
   logic [LEN_W-1:0]      len_minus_one;
   logic [ADDR_W-1:0]     append_border;
   logic                  match_w;
   logic [COUNT_BITS-1:0] count_w;

   step_ctrl_type         step_ctrl;
   logic [ADDR_W-1:0]     step_k;
   logic                  step_done;
   logic [LEN_W-1:0]      step_res;

   logic                  pat_we;
   logic                  link_we;
   logic [ADDR_W-1:0]     link_rd_addr;
   logic [SYM_W-1:0]      pat_rd_data;
   logic [ADDR_W-1:0]     link_rd_data;

   assign req.ready     = (state_ff == ST_IDLE);
   assign req_xfer      = req.valid && req.ready;
   assign commit        = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp.ready);
   assign full          = (len_ff >= LEN_W'(MAX_PATTERN));
   assign len_minus_one = len_ff - LEN_W'(1);
   // an append to an empty pattern has no border; otherwise the walk result
   assign append_border = (len_ff == '0) ? '0 : step_res[ADDR_W-1:0];

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req.func)
                  FUNC_APPEND: begin
                     state_in = (!full && len_ff != '0) ? ST_SEED : ST_RESP;
                  end
                  FUNC_TEXT: begin
                     state_in = (len_ff != '0) ? ST_FETCH : ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SEED:      state_in = ST_SEED_LOAD;
         ST_SEED_LOAD: state_in = ST_FETCH;
         ST_FETCH:     state_in = ST_COMPARE;
         ST_COMPARE: begin
            state_in = step_done ? ST_RESP : ST_FETCH;
         end
         ST_RESP: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer outputs: step unit control, store ports
   // ------------------------------------------------------------------
   always_comb begin
      step_ctrl.load_start = req_xfer;
      step_ctrl.load_seed  = (state_ff == ST_SEED_LOAD);
      step_ctrl.step       = (state_ff == ST_COMPARE);
      // write the symbol on transfer so the walk can read it back
      pat_we  = req_xfer && (req.func == FUNC_APPEND) && !full;
      link_we = commit && (func_ff == FUNC_APPEND) && !full;
      // seed read fetches the link of the last stored symbol
      link_rd_addr = (state_ff == ST_SEED) ? len_minus_one[ADDR_W-1:0]
                                           : (step_k - ADDR_W'(1));
   end

   // ------------------------------------------------------------------
   // Datapath next values: item latch, matcher state, output register
   // ------------------------------------------------------------------
   always_comb begin
      func_in         = func_ff;
      sym_in          = sym_ff;
      last_in         = last_ff;
      len_in          = len_ff;
      matched_in      = matched_ff;
      border_in       = border_ff;
      occ_in          = occ_ff;
      dropped_in      = dropped_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_match_in    = rsp_match_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_border_in   = rsp_border_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_overflow_in = rsp_overflow_ff;
      match_w         = 1'b0;
      count_w         = occ_ff;

      if (req_xfer) begin
         func_in = req.func;
         sym_in  = req.symbol[SYM_W-1:0];
         last_in = req.last;
      end

      if (commit) begin
         case (func_ff)
            FUNC_CLEAR: begin
               // the count of the current text survives a clear
               len_in     = '0;
               matched_in = '0;
               border_in  = '0;
               dropped_in = 1'b0;
            end
            FUNC_APPEND: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  len_in    = len_ff + LEN_W'(1);
                  border_in = append_border;
               end
            end
            FUNC_TEXT: begin
               if (len_ff != '0) begin
                  if (step_res >= len_ff) begin
                     match_w    = 1'b1;
                     count_w    = (occ_ff == '1) ? occ_ff : occ_ff + COUNT_BITS'(1);
                     // drop back to the border so overlaps are found
                     matched_in = border_ff;
                  end else begin
                     matched_in = step_res[ADDR_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase

         occ_in          = count_w;
         rsp_valid_in    = 1'b1;
         rsp_match_in    = match_w;
         rsp_count_in    = count_w;
         rsp_border_in   = LEN_PORT_BITS'(border_in);
         rsp_length_in   = LEN_PORT_BITS'(len_in);
         rsp_overflow_in = dropped_in;

         // end of text: report first, then restart position and count
         if (func_ff == FUNC_TEXT && last_ff) begin
            matched_in = '0;
            occ_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         matched_ff   <= '0;
         border_ff    <= '0;
         occ_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         matched_ff   <= matched_in;
         border_ff    <= border_in;
         occ_ff       <= occ_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      sym_ff          <= sym_in;
      last_ff         <= last_in;
      rsp_match_ff    <= rsp_match_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_border_ff   <= rsp_border_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.match          = rsp_match_ff;
   assign rsp.match_count    = rsp_count_ff;
   assign rsp.border_length  = rsp_border_ff;
   assign rsp.pattern_length = rsp_length_ff;
   assign rsp.overflow       = rsp_overflow_ff;

   // ------------------------------------------------------------------
   // Stores and shared step unit
   // ------------------------------------------------------------------
   kms_stores #(
      .MAX_PATTERN (MAX_PATTERN),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_stores (
      .clock        (clock),
      .pat_we       (pat_we),
      .pat_wr_addr  (len_ff[ADDR_W-1:0]),
      .pat_wr_data  (req.symbol[SYM_W-1:0]),
      .pat_rd_addr  (step_k),
      .pat_rd_data  (pat_rd_data),
      .link_we      (link_we),
      .link_wr_addr (len_ff[ADDR_W-1:0]),
      .link_wr_data (append_border),
      .link_rd_addr (link_rd_addr),
      .link_rd_data (link_rd_data)
   );

   kms_step_unit #(
      .MAX_PATTERN (MAX_PATTERN),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_step (
      .clock        (clock),
      .ctrl         (step_ctrl),
      .start_k      (matched_ff),
      .symbol       (sym_ff),
      .pat_rd_data  (pat_rd_data),
      .link_rd_data (link_rd_data),
      .k            (step_k),
      .done         (step_done),
      .result       (step_res)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_matched_below_length: assert property (@(posedge clock) disable iff (reset)
      (LEN_W'(matched_ff) < len_ff) || (len_ff == '0 && matched_ff == '0))
      else $error("matched prefix not below pattern length");

   a_border_below_length: assert property (@(posedge clock) disable iff (reset)
      (LEN_W'(border_ff) < len_ff) || (len_ff == '0 && border_ff == '0))
      else $error("border not below pattern length");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond capacity");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result load did not present a result");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kmp_stream_matcher
// Streams clear, append and text items through the req channel and checks
// every rsp transfer against a behavioral Knuth-Morris-Pratt predictor kept
// in step with the block. A short directed list covers the corner cases,
// then random episodes build small patterns over small alphabets, scan text
// against them and sprinkle in noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import kms_pkg::*;

   localparam int                   MAX_PATTERN   = MAX_PATTERN_DEFAULT;
   localparam logic [FUNC_BITS-1:0] FUNC_RESERVED = 2'd3;
   localparam int                   RANDOM_ITEMS  = 1250;
   localparam int                   QUIET_LIMIT   = 20000;
   localparam int                   TAIL_CYCLES   = 40;

   typedef struct {
      logic [FUNC_BITS-1:0]        func;
      logic [SYMBOL_PORT_BITS-1:0] symbol;
      logic                        last;
      bit                          drain_first;  // hold off until all results are in
   } kmp_item_type;

   typedef struct {
      logic                     match;
      logic [COUNT_BITS-1:0]    count;
      logic [LEN_PORT_BITS-1:0] border;
      logic [LEN_PORT_BITS-1:0] length;
      logic                     overflow;
   } kmp_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kms_req_if req_ch ();
   kms_rsp_if rsp_ch ();

   kmp_stream_matcher uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Matcher state mirrored by the predictor
   // -------------------------------------------------------------------------
   logic [SYMBOL_PORT_BITS-1:0] pattern_mem [MAX_PATTERN];
   logic [LEN_PORT_BITS-1:0]    border_mem  [MAX_PATTERN];
   int unsigned                 pattern_len = 0;
   int unsigned                 prefix_pos  = 0;
   logic [COUNT_BITS-1:0]       hit_count   = '0;
   logic                        dropped     = 1'b0;

   kmp_item_type   item_q[$];     // items waiting for the driver
   kmp_report_type report_q[$];   // predicted results waiting for the monitor
   kmp_item_type   cur_item;
   int unsigned    mismatches = 0;

   // Advance a matched-prefix length by one symbol, following border links
   // on mismatch. Only entries below pattern_len are ever read.
   function automatic int unsigned advance_prefix(int unsigned k,
                                                  logic [SYMBOL_PORT_BITS-1:0] c);
      while (k > 0 && c != pattern_mem[k])
         k = border_mem[k-1];
      if (c == pattern_mem[k])
         k++;
      return k;
   endfunction

   // Apply one accepted item to the mirrored state and return its result.
   function automatic kmp_report_type predict_report(kmp_item_type it);
      kmp_report_type r;
      int unsigned k;
      r.match = 1'b0;
      case (it.func)
         FUNC_CLEAR: begin
            pattern_len = 0;
            prefix_pos  = 0;
            dropped     = 1'b0;
         end
         FUNC_APPEND: begin
            if (pattern_len >= MAX_PATTERN) begin
               dropped = 1'b1;
            end else begin
               pattern_mem[pattern_len] = it.symbol;
               k = 0;
               if (pattern_len > 0)
                  k = advance_prefix(border_mem[pattern_len-1], it.symbol);
               if (k > pattern_len)
                  k = pattern_len;
               border_mem[pattern_len] = k[LEN_PORT_BITS-1:0];
               pattern_len++;
            end
         end
         FUNC_TEXT: begin
            if (pattern_len > 0) begin
               k = advance_prefix(prefix_pos, it.symbol);
               if (k >= pattern_len) begin
                  r.match = 1'b1;
                  if (hit_count != '1)
                     hit_count++;
                  // fall back to the whole-pattern border so overlaps count
                  k = border_mem[pattern_len-1];
               end
               prefix_pos = k;
            end
         end
         default: ;
      endcase
      r.count    = hit_count;
      r.border   = (pattern_len > 0) ? border_mem[pattern_len-1] : '0;
      r.length   = pattern_len[LEN_PORT_BITS-1:0];
      r.overflow = dropped;
      // last ends the text only after the result is taken
      if (it.func == FUNC_TEXT && it.last) begin
         prefix_pos = 0;
         hit_count  = '0;
      end
      return r;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Driver: present queued items on req, one transfer each
   // -------------------------------------------------------------------------
   int unsigned send_gap   = 0;
   bit          send_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = $urandom_range(0, 9);
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            // predict at the transfer, in acceptance order
            report_q = {report_q, predict_report(cur_item)};
            // toggle now and then into a stretch with no gaps at all
            if ($urandom_range(0, 49) == 0)
               send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 9);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the item until it is taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (item_q.size() > 0 &&
                      !(item_q[0].drain_first && report_q.size() > 0)) begin
            cur_item = item_q.pop_front();
            req_ch.valid  <= 1'b1;
            req_ch.func   <= cur_item.func;
            req_ch.symbol <= cur_item.symbol;
            req_ch.last   <= cur_item.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: stall rsp at random and check each transfer in order
   // -------------------------------------------------------------------------
   int unsigned    recv_stall = 0;
   bit             recv_burst = 1'b0;
   kmp_report_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall = $urandom_range(0, 9);
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (report_q.size() == 0) begin
               $error("result transfer with no result pending");
               mismatches++;
            end else begin
               want = report_q.pop_front();
               compare_field("match", want.match, rsp_ch.match);
               compare_field("match_count", want.count, rsp_ch.match_count);
               compare_field("border_length", want.border, rsp_ch.border_length);
               compare_field("pattern_length", want.length, rsp_ch.pattern_length);
               compare_field("overflow", want.overflow, rsp_ch.overflow);
            end
            if ($urandom_range(0, 49) == 0)
               recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 9);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run after too long without any transfer
   // -------------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   logic [SYMBOL_PORT_BITS-1:0] alphabet [4];
   int unsigned                 alpha_size = 1;

   task automatic add_item(input logic [FUNC_BITS-1:0] func,
                           input logic [SYMBOL_PORT_BITS-1:0] symbol,
                           input logic last, input bit drain_first = 1'b0);
      kmp_item_type it;
      it.func        = func;
      it.symbol      = symbol;
      it.last        = last;
      it.drain_first = drain_first;
      item_q = {item_q, it};
   endtask

   // Mostly draw from the episode alphabet so matches happen; now and then
   // throw in a fully random symbol.
   function automatic logic [SYMBOL_PORT_BITS-1:0] pick_symbol();
      if ($urandom_range(0, 11) == 0)
         return $urandom;
      return alphabet[$urandom_range(0, alpha_size - 1)];
   endfunction

   initial begin
      int unsigned                 random_count;
      int unsigned                 plen;
      int unsigned                 tlen;
      int unsigned                 i;
      bit                          drain;
      bit                          filled;
      logic [SYMBOL_PORT_BITS-1:0] fill_symbol;

      // drive every block input to a known value from time zero
      req_ch.valid  = 1'b0;
      req_ch.func   = FUNC_CLEAR;
      req_ch.symbol = '0;
      req_ch.last   = 1'b0;
      rsp_ch.ready  = 1'b0;

      // --- directed part ---
      // text against an empty pattern, with and without last
      add_item(FUNC_TEXT, 32'h0000_0000, 1'b0);
      add_item(FUNC_TEXT, 32'hFFFF_FFFF, 1'b1);
      add_item(FUNC_RESERVED, 32'hFFFF_FFFF, 1'b0);
      // pattern F 0 F has border 1; text F0F0F matches twice, overlapping
      add_item(FUNC_APPEND, 32'hFFFF_FFFF, 1'b0);
      add_item(FUNC_APPEND, 32'h0000_0000, 1'b0);
      add_item(FUNC_APPEND, 32'hFFFF_FFFF, 1'b0);
      add_item(FUNC_TEXT, 32'hFFFF_FFFF, 1'b0);
      add_item(FUNC_TEXT, 32'h0000_0000, 1'b0);
      add_item(FUNC_TEXT, 32'hFFFF_FFFF, 1'b0);
      add_item(FUNC_TEXT, 32'h0000_0000, 1'b0);
      add_item(FUNC_TEXT, 32'hFFFF_FFFF, 1'b1);
      // last on an append and on a clear is ignored
      add_item(FUNC_APPEND, 32'h0000_0000, 1'b1);
      add_item(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b1);
      add_item(FUNC_TEXT, 32'h5A5A_5A5A, 1'b0);
      // single-symbol pattern, then grow it in the middle of a text
      add_item(FUNC_APPEND, 32'hA5A5_A5A5, 1'b0);
      add_item(FUNC_TEXT, 32'h5A5A_5A5A, 1'b0);
      add_item(FUNC_TEXT, 32'hA5A5_A5A5, 1'b0);
      add_item(FUNC_TEXT, 32'hA5A5_A5A5, 1'b0);
      add_item(FUNC_APPEND, 32'h1234_5678, 1'b0);
      add_item(FUNC_TEXT, 32'h1234_5678, 1'b0);
      add_item(FUNC_RESERVED, 32'h0000_0000, 1'b1);
      // clear mid-text keeps the count, then an empty-pattern text ends it
      add_item(FUNC_CLEAR, 32'h0000_0000, 1'b0);
      add_item(FUNC_TEXT, 32'hA5A5_A5A5, 1'b1);
      add_item(FUNC_TEXT, 32'hA5A5_A5A5, 1'b0, 1'b1);

      // --- random episodes ---
      random_count = 0;
      filled       = 1'b0;
      while (random_count < RANDOM_ITEMS) begin
         if (!filled && random_count >= RANDOM_ITEMS / 2) begin
            // fill to capacity with one symbol (border 1023), drop a few
            // more appends, then scan a short text against the full pattern
            filled      = 1'b1;
            fill_symbol = $urandom;
            add_item(FUNC_CLEAR, $urandom, 1'($urandom_range(0, 1)), 1'b1);
            for (i = 0; i < MAX_PATTERN + 3; i++)
               add_item(FUNC_APPEND, fill_symbol, 1'($urandom_range(0, 1)));
            for (i = 0; i < 48; i++)
               add_item(FUNC_TEXT, ($urandom_range(0, 7) == 0) ? $urandom : fill_symbol,
                        i == 47);
            random_count += MAX_PATTERN + 52;
         end

         alpha_size = $urandom_range(1, 3);
         for (i = 0; i < alpha_size; i++)
            alphabet[i] = $urandom;
         drain = ($urandom_range(0, 7) == 0);

         if ($urandom_range(0, 3) != 0) begin
            add_item(FUNC_CLEAR, $urandom, 1'($urandom_range(0, 1)), drain);
            drain = 1'b0;
            random_count++;
         end

         plen = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
         for (i = 0; i < plen; i++) begin
            add_item(FUNC_APPEND, pick_symbol(), 1'($urandom_range(0, 1)), drain);
            drain = 1'b0;
            random_count++;
         end

         tlen = $urandom_range(1, 40);
         for (i = 0; i < tlen; i++) begin
            // noise: a reserved code, a stray clear or an append mid-text
            if ($urandom_range(0, 29) == 0) begin
               case ($urandom_range(0, 2))
                  0: begin
                     add_item(FUNC_RESERVED, $urandom, 1'($urandom_range(0, 1)));
                     random_count++;
                  end
                  1: begin
                     add_item(FUNC_CLEAR, $urandom, 1'($urandom_range(0, 1)));
                     random_count++;
                  end
                  default: begin
                     add_item(FUNC_APPEND, pick_symbol(), 1'($urandom_range(0, 1)));
                     random_count++;
                  end
               endcase
            end
            // usually close the text on its final symbol; sometimes run on
            // into the next episode or end early
            add_item(FUNC_TEXT, pick_symbol(),
                     (i == tlen - 1) ? ($urandom_range(0, 7) != 0)
                                     : ($urandom_range(0, 39) == 0));
            random_count++;
         end
      end

      // release reset
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait until every item is taken and every result is checked
      do
         @(posedge clock);
      while (item_q.size() != 0 || req_ch.valid || report_q.size() != 0);

      // let any stray result show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* kmp_stream_matcher.f */
design/kms_pkg.sv
design/kms_req_if.sv
design/kms_rsp_if.sv
design/kms_stores.sv
design/kms_step_unit.sv
design/kmp_stream_matcher.sv
tb/testbench.sv
